// File: src/cubic_row_upsampler_macros.svh
// Assertion macros for the cubic row upsampler.
// Included by every RTL file that carries concurrent assertions; no other dependencies.
`ifndef CUBIC_ROW_UPSAMPLER_MACROS_SVH
`define CUBIC_ROW_UPSAMPLER_MACROS_SVH
`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define CRU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// The condition must never be true at a clock edge outside reset.
`define CRU_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define CRU_ASSERT(lbl, clk, rstn, prop, msg)
`define CRU_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// File: src/cru_pkg.sv
// Shared types, constants and helper functions of the cubic row upsampler.
// No dependencies; used by the front end, the command queue, the back end and the top level.
package cru_pkg;

  localparam int DataW  = 16;
  localparam int WgtW   = 18;
  localparam int QDepth = 2;

  // One unit of work for the back end: either a segment (left sample plus
  // interpolated points) or the final sample of a row.
  typedef struct packed {
    logic                    fin;
    logic signed [DataW-1:0] p0;
    logic signed [DataW-1:0] p1;
    logic signed [DataW-1:0] p2;
    logic signed [DataW-1:0] p3;
  } cmd_t;

  // Catmull-Rom weight numerators over the denominator 2*d^3.
  function automatic longint cru_num0(input longint n, input longint d);
    return -n * d * d + 2 * n * n * d - n * n * n;
  endfunction

  function automatic longint cru_num2(input longint n, input longint d);
    return n * d * d + 4 * n * n * d - 3 * n * n * n;
  endfunction

  function automatic longint cru_num3(input longint n, input longint d);
    return -n * n * d + n * n * n;
  endfunction

  function automatic cmd_t seg_cmd(input logic signed [DataW-1:0] a,
                                   input logic signed [DataW-1:0] b,
                                   input logic signed [DataW-1:0] c,
                                   input logic signed [DataW-1:0] e);
    cmd_t r;
    r.fin = 1'b0;
    r.p0  = a;
    r.p1  = b;
    r.p2  = c;
    r.p3  = e;
    return r;
  endfunction

  // The final sample rides in p1, so identity weights pass it through unchanged.
  function automatic cmd_t fin_cmd(input logic signed [DataW-1:0] s);
    cmd_t r;
    r.fin = 1'b1;
    r.p0  = '0;
    r.p1  = s;
    r.p2  = '0;
    r.p3  = '0;
    return r;
  endfunction

endpackage

// File: src/cru_front.sv
// Front end of the cubic row upsampler: sample window, row bookkeeping, command generation.
// Depends on cru_pkg and cubic_row_upsampler_macros.svh.
`include "cubic_row_upsampler_macros.svh"
module cru_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [cru_pkg::DataW-1:0] sample_i,
  input  logic                             row_end_i,
  output logic                             push_o,
  output cru_pkg::cmd_t                    cmd_o,
  input  logic                             full_i
);
  import cru_pkg::*;

  localparam logic [1:0] FL_NONE  = 2'd0;
  localparam logic [1:0] FL_TAIL  = 2'd1;
  localparam logic [1:0] FL_FINAL = 2'd2;

  logic signed [DataW-1:0] win0_q, win0_d, win1_q, win1_d, win2_q, win2_d;
  logic signed [DataW-1:0] fin_q, fin_d;
  logic [1:0]              cnt_q, cnt_d;
  logic [1:0]              fl_q, fl_d;
  cmd_t                    pend_q, pend_d;
  logic                    accept;

  assign in_stall_o = (fl_q != FL_NONE) || full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    push_o = 1'b0;
    cmd_o  = '0;
    win0_d = win0_q;
    win1_d = win1_q;
    win2_d = win2_q;
    fin_d  = fin_q;
    cnt_d  = cnt_q;
    fl_d   = fl_q;
    pend_d = pend_q;
    unique case (fl_q)
      FL_TAIL: begin
        if (!full_i) begin
          push_o = 1'b1;
          cmd_o  = pend_q;
          fl_d   = FL_FINAL;
        end
      end
      FL_FINAL: begin
        if (!full_i) begin
          push_o = 1'b1;
          cmd_o  = fin_cmd(fin_q);
          fl_d   = FL_NONE;
        end
      end
      default: begin
        if (accept) begin
          case (cnt_q)
            2'd0: begin
              if (row_end_i) begin
                push_o = 1'b1;
                cmd_o  = fin_cmd(sample_i);
              end else begin
                win0_d = sample_i;
                cnt_d  = 2'd1;
              end
            end
            2'd1: begin
              if (row_end_i) begin
                push_o = 1'b1;
                cmd_o  = seg_cmd(win0_q, win0_q, sample_i, sample_i);
                fin_d  = sample_i;
                fl_d   = FL_FINAL;
                cnt_d  = 2'd0;
              end else begin
                win1_d = sample_i;
                cnt_d  = 2'd2;
              end
            end
            2'd2: begin
              push_o = 1'b1;
              cmd_o  = seg_cmd(win0_q, win0_q, win1_q, sample_i);
              if (row_end_i) begin
                pend_d = seg_cmd(win0_q, win1_q, sample_i, sample_i);
                fin_d  = sample_i;
                fl_d   = FL_TAIL;
                cnt_d  = 2'd0;
              end else begin
                win2_d = sample_i;
                cnt_d  = 2'd3;
              end
            end
            default: begin
              push_o = 1'b1;
              cmd_o  = seg_cmd(win0_q, win1_q, win2_q, sample_i);
              if (row_end_i) begin
                pend_d = seg_cmd(win1_q, win2_q, sample_i, sample_i);
                fin_d  = sample_i;
                fl_d   = FL_TAIL;
                cnt_d  = 2'd0;
              end else begin
                win0_d = win1_q;
                win1_d = win2_q;
                win2_d = sample_i;
              end
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      fl_q  <= FL_NONE;
    end else begin
      cnt_q <= cnt_d;
      fl_q  <= fl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win0_q <= win0_d;
    win1_q <= win1_d;
    win2_q <= win2_d;
    fin_q  <= fin_d;
    pend_q <= pend_d;
  end

  `CRU_ASSERT(a_row_end_clears, clk_i, rst_ni, (accept && row_end_i) |=> (cnt_q == 2'd0), "row end did not empty the window")

endmodule

// File: src/cru_queue.sv
// Short command queue between the front end and the back end of the cubic row upsampler.
// Depends on cru_pkg and cubic_row_upsampler_macros.svh.
`include "cubic_row_upsampler_macros.svh"
module cru_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cru_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output cru_pkg::cmd_t pop_data_o,
  output logic          empty_o
);
  import cru_pkg::*;

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  cmd_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == CntW'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `CRU_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o, "push into a full command queue")
  `CRU_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && empty_o, "pop from an empty command queue")

endmodule

// File: src/cru_back.sv
// Back end of the cubic row upsampler: point sequencer and pipelined Catmull-Rom datapath.
// Depends on cru_pkg and cubic_row_upsampler_macros.svh.
`include "cubic_row_upsampler_macros.svh"
module cru_back #(
  parameter int INSERTED_POINTS = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             empty_i,
  input  cru_pkg::cmd_t                    cmd_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [cru_pkg::DataW-1:0] value_o,
  output logic                             last_o
);
  import cru_pkg::*;

  localparam int     NW   = INSERTED_POINTS + 1;
  localparam int     NB   = $clog2(NW);
  localparam longint D    = longint'(INSERTED_POINTS) + 1;
  localparam longint Den  = 2 * D * D * D;
  localparam int     PrdW = DataW + WgtW;
  localparam int     PrW  = PrdW + 1;
  localparam int     SumW = PrdW + 2;
  localparam int     QW   = SumW - 16;

  logic signed [WgtW-1:0] w0_tab [NW];
  logic signed [WgtW-1:0] w1_tab [NW];
  logic signed [WgtW-1:0] w2_tab [NW];
  logic signed [WgtW-1:0] w3_tab [NW];

  // Q.16 weights per point index; index 0 is the identity used for plain samples.
  for (genvar gi = 0; gi < NW; gi++) begin : g_wgt
    localparam longint N0 = cru_num0(gi, D);
    localparam longint N2 = cru_num2(gi, D);
    localparam longint N3 = cru_num3(gi, D);
    localparam longint W0 = (N0 < 0) ? -((-N0 * 65536 + Den / 2) / Den)
                                     : ((N0 * 65536 + Den / 2) / Den);
    localparam longint W2 = (N2 < 0) ? -((-N2 * 65536 + Den / 2) / Den)
                                     : ((N2 * 65536 + Den / 2) / Den);
    localparam longint W3 = (N3 < 0) ? -((-N3 * 65536 + Den / 2) / Den)
                                     : ((N3 * 65536 + Den / 2) / Den);
    localparam longint W1 = 65536 - W0 - W2 - W3;
    assign w0_tab[gi] = WgtW'(W0);
    assign w1_tab[gi] = WgtW'(W1);
    assign w2_tab[gi] = WgtW'(W2);
    assign w3_tab[gi] = WgtW'(W3);
  end

  // Sequencer state.
  cmd_t          cur_q;
  logic          busy_q;
  logic [NB-1:0] n_q;
  logic          adv, issue, last_op, load;

  // Pipeline registers.
  logic                    s1_valid_q, s1_last_q;
  logic signed [DataW-1:0] s1_p0_q, s1_p1_q, s1_p2_q, s1_p3_q;
  logic signed [WgtW-1:0]  s1_w0_q, s1_w1_q, s1_w2_q, s1_w3_q;
  logic                    s2_valid_q, s2_last_q;
  logic signed [PrdW-1:0]  s2_m0_q, s2_m1_q, s2_m2_q, s2_m3_q;
  logic                    s3_valid_q, s3_last_q;
  logic signed [PrW-1:0]   s3_a_q, s3_b_q;
  logic                    out_valid_q, out_last_q;
  logic signed [DataW-1:0] out_value_q;

  logic signed [SumW-1:0]  sum;
  logic                    corr;
  logic signed [QW:0]      trunc;
  logic signed [DataW-1:0] sat;

  assign adv     = !out_valid_q || !out_stall_i;
  assign issue   = busy_q && adv;
  assign last_op = cur_q.fin || (n_q == NB'(INSERTED_POINTS));
  assign load    = !empty_i && (!busy_q || (issue && last_op));
  assign pop_o   = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      n_q    <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      n_q    <= '0;
    end else if (issue && last_op) begin
      busy_q <= 1'b0;
    end else if (issue) begin
      n_q <= n_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= issue;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // Truncate toward zero, then clamp to the 16-bit range.
  always_comb begin
    sum   = SumW'(s3_a_q) + SumW'(s3_b_q);
    corr  = sum[SumW-1] && (sum[15:0] != '0);
    trunc = (QW + 1)'($signed(sum[SumW-1:16])) + $signed({{QW{1'b0}}, corr});
    if (trunc > (QW + 1)'(32767)) begin
      sat = 16'sh7fff;
    end else if (trunc < -(QW + 1)'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = trunc[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_last_q   <= cur_q.fin;
      s1_p0_q     <= cur_q.p0;
      s1_p1_q     <= cur_q.p1;
      s1_p2_q     <= cur_q.p2;
      s1_p3_q     <= cur_q.p3;
      s1_w0_q     <= w0_tab[n_q];
      s1_w1_q     <= w1_tab[n_q];
      s1_w2_q     <= w2_tab[n_q];
      s1_w3_q     <= w3_tab[n_q];
      s2_last_q   <= s1_last_q;
      s2_m0_q     <= s1_w0_q * s1_p0_q;
      s2_m1_q     <= s1_w1_q * s1_p1_q;
      s2_m2_q     <= s1_w2_q * s1_p2_q;
      s2_m3_q     <= s1_w3_q * s1_p3_q;
      s3_last_q   <= s2_last_q;
      s3_a_q      <= PrW'(s2_m0_q) + PrW'(s2_m1_q);
      s3_b_q      <= PrW'(s2_m2_q) + PrW'(s2_m3_q);
      out_last_q  <= s3_last_q;
      out_value_q <= sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_value_q;
  assign last_o      = out_last_q;

  `CRU_ASSERT(a_final_identity, clk_i, rst_ni, (issue && cur_q.fin) |-> (n_q == '0), "final sample issued with interpolation weights")
  `CRU_ASSERT_NEVER(a_index_range, clk_i, rst_ni, busy_q && (n_q > NB'(INSERTED_POINTS)), "point index beyond the inserted count")

endmodule

// File: src/cubic_row_upsampler.sv
// Top level of the cubic row upsampler: front end, command queue and back end.
// Depends on cru_pkg, cru_front, cru_queue, cru_back and cubic_row_upsampler_macros.svh.
//
// Catmull-Rom row upsampler. Height samples of one row arrive one per input
// transaction; for every segment the block sends out the left sample followed
// by INSERTED_POINTS interpolated values, clamping the missing neighbor at
// either end of the row to the end sample, and on row_end it flushes the open
// segments and the final sample with last set. Interpolated values use Q.16
// weights, are truncated toward zero and saturate to 16 bits. The back end
// produces one output transaction per clock while the output is not stalled,
// through a single four-tap multiply-add pipeline, and it loads the next
// command as it issues the last point of the current one. The first two
// samples of a row, unless the second ends the row, and a lone row-end sample
// produce no segment. A row-end sample yields up to three commands, which the
// front end hands over one after another, holding the input until the last
// one is pushed; together they give up to 2*INSERTED_POINTS+3 outputs. An
// accepted sample's commands pass through the queue, the sequencer's command
// register and the s1, s2, s3 and output registers on the way out. A two-entry
// queue between the front and back ends lets the input keep moving while the
// datapath or the output register is stalled; a waiting result in the output
// register does not stop the input side until that queue fills.
module cubic_row_upsampler #(
  parameter int INSERTED_POINTS = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [cru_pkg::DataW-1:0] sample_i,
  input  logic                             row_end_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [cru_pkg::DataW-1:0] value_o,
  output logic                             last_o
);
  import cru_pkg::*;

  // Front to queue.
  logic push, full;
  cmd_t push_cmd;

  // Queue to back end.
  logic pop, empty;
  cmd_t pop_cmd;

  // The front end owns the three-sample window and turns the samples into
  // segment and final-sample commands.
  cru_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .row_end_i  (row_end_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  cru_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (empty)
  );

  // The back end walks each command point by point and owns the output register.
  cru_back #(
    .INSERTED_POINTS (INSERTED_POINTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .last_o      (last_o)
  );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the cubic row upsampler: feeds rows of height samples
// and checks every output height against a Catmull-Rom predictor. Depends on cru_pkg.
module tb_top;

  localparam int InsertedPoints = 1;
  localparam int HalfPeriod     = 6;
  localparam int ResetCycles    = 4;
  localparam int RandomItems    = 85;
  localparam int HoldCycles     = 80;
  // Covers the path from sample to first output, plus the command queue and slack.
  localparam int DrainCycles    = 40;
  localparam int ReportLimit    = 10;

  // Idle modes: which side idles how often.
  localparam int ModeSenderLight = 0;  // sender 25 %, receiver 49 %
  localparam int ModeSenderHeavy = 1;  // sender 49 %, receiver 25 %
  localparam int ModeNoIdle      = 2;

  typedef logic signed [cru_pkg::DataW-1:0] height_t;

  typedef struct packed {
    height_t value;
    logic    last;
  } height_out_t;

  // One row of the directed table. When flat is set, every output height that the
  // transaction causes is simply its own sample, which can be seen without any
  // arithmetic: a lone sample, or a row whose samples are all the same.
  typedef struct packed {
    height_t sample;
    logic    row_end;
    logic    flat;
  } stim_row_t;

  logic    clk_i;
  logic    rst_ni;
  logic    in_valid_i;
  logic    in_stall_o;
  height_t sample_i;
  logic    row_end_i;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  height_t value_o;
  logic    last_o;

  cubic_row_upsampler #(
    .INSERTED_POINTS(InsertedPoints)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_i   (sample_i),
    .row_end_i  (row_end_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_o    (value_o),
    .last_o     (last_o)
  );

  always begin
    clk_i = 1'b1;
    #HalfPeriod;
    clk_i = 1'b0;
    #HalfPeriod;
  end

  // Directed rows: lone samples at both extremes, flat two-sample rows, a short
  // two-sample and three-sample row, overshoot in both directions through the
  // inner segments of two four-sample rows, and alternating bit patterns.
  stim_row_t directed_rows [25] = '{
    '{16'sd100,   1'b1, 1'b1},
    '{16'h8000,   1'b1, 1'b1},
    '{16'h7fff,   1'b1, 1'b1},
    '{16'h7fff,   1'b0, 1'b0},
    '{16'h7fff,   1'b1, 1'b1},
    '{16'h8000,   1'b0, 1'b0},
    '{16'h8000,   1'b1, 1'b1},
    '{16'sd1000,  1'b0, 1'b0},
    '{-16'sd2000, 1'b1, 1'b0},
    '{16'sd5,     1'b0, 1'b0},
    '{16'sd300,   1'b0, 1'b0},
    '{-16'sd7,    1'b1, 1'b0},
    '{16'h8000,   1'b0, 1'b0},
    '{16'h7fff,   1'b0, 1'b0},
    '{16'h7fff,   1'b0, 1'b0},
    '{16'h8000,   1'b1, 1'b0},
    '{16'h7fff,   1'b0, 1'b0},
    '{16'h8000,   1'b0, 1'b0},
    '{16'h8000,   1'b0, 1'b0},
    '{16'h7fff,   1'b1, 1'b0},
    '{16'h5555,   1'b0, 1'b0},
    '{16'haaaa,   1'b0, 1'b0},
    '{16'h0001,   1'b0, 1'b0},
    '{16'hffff,   1'b0, 1'b0},
    '{16'h0000,   1'b1, 1'b0}
  };

  // Heights still owed by the block, oldest first, and the ones caused by the
  // transaction that the predictor is working on.
  height_out_t pending_heights[$];
  height_out_t step_heights[$];

  // Predictor state: the samples of the open row, oldest first, and their count.
  height_t     row_buf [3];
  int unsigned row_fill;

  int idle_mode;
  int fail_count;
  int heights_checked;
  int samples_sent;
  int rows_sent;
  int random_sent;

  // Q.16 weight from a numerator over den, rounded to nearest, ties away from zero.
  function automatic longint q16_round(input longint num, input longint den);
    longint mag;
    longint r;
    mag = (num < 0) ? -num : num;
    r = (mag * 65536 + den / 2) / den;
    return (num < 0) ? -r : r;
  endfunction

  // Interpolated height at x = n/(InsertedPoints+1) between p1 and p2.
  function automatic height_t catmull_point(input height_t p0, input height_t p1,
                                            input height_t p2, input height_t p3,
                                            input longint n);
    longint d;
    longint den;
    longint w0;
    longint w1;
    longint w2;
    longint w3;
    longint acc;
    longint v;
    d   = InsertedPoints + 1;
    den = 2 * d * d * d;
    w0  = q16_round(-n * d * d + 2 * n * n * d - n * n * n, den);
    w2  = q16_round(n * d * d + 4 * n * n * d - 3 * n * n * n, den);
    w3  = q16_round(-n * n * d + n * n * n, den);
    // The four weights sum to exactly one.
    w1  = 65536 - w0 - w2 - w3;
    acc = w0 * longint'(p0) + w1 * longint'(p1) + w2 * longint'(p2) + w3 * longint'(p3);
    // SystemVerilog division truncates toward zero, as the block does.
    v = acc / 65536;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return height_t'(v);
  endfunction

  function automatic void push_height(input height_t v, input logic last);
    height_out_t h;
    h.value = v;
    h.last  = last;
    step_heights.push_back(h);
  endfunction

  // A segment is its left sample followed by the interpolated points.
  function automatic void push_segment(input height_t p0, input height_t p1,
                                       input height_t p2, input height_t p3);
    push_height(p1, 1'b0);
    for (int n = 1; n <= InsertedPoints; n++) begin
      push_height(catmull_point(p0, p1, p2, p3, n), 1'b0);
    end
  endfunction

  // Advances the predicted row by one sample. At a row end the open segments are
  // flushed with the right neighbor clamped to the final sample, which follows
  // with last set; the row then starts over empty.
  function automatic void predict_row_step(input height_t s, input logic row_end);
    step_heights.delete();
    case (row_fill)
      0: begin
        if (row_end) begin
          push_height(s, 1'b1);
        end else begin
          row_buf[0] = s;
          row_fill   = 1;
        end
      end
      1: begin
        if (row_end) begin
          push_segment(row_buf[0], row_buf[0], s, s);
          push_height(s, 1'b1);
        end else begin
          row_buf[1] = s;
          row_fill   = 2;
        end
      end
      2: begin
        // First segment of the row: the left neighbor is clamped to the first sample.
        push_segment(row_buf[0], row_buf[0], row_buf[1], s);
        if (row_end) begin
          push_segment(row_buf[0], row_buf[1], s, s);
          push_height(s, 1'b1);
        end else begin
          row_buf[2] = s;
          row_fill   = 3;
        end
      end
      default: begin
        push_segment(row_buf[0], row_buf[1], row_buf[2], s);
        if (row_end) begin
          push_segment(row_buf[1], row_buf[2], s, s);
          push_height(s, 1'b1);
        end else begin
          row_buf[0] = row_buf[1];
          row_buf[1] = row_buf[2];
          row_buf[2] = s;
        end
      end
    endcase
    if (row_end) begin
      row_buf  = '{default: '0};
      row_fill = 0;
    end
  endfunction

  // Mostly arbitrary heights, with the extremes and the values around zero mixed in.
  function automatic height_t random_height();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(3))
          0:       return 16'h7fff;
          1:       return 16'h8000;
          2:       return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      default: return height_t'($urandom());
    endcase
  endfunction

  // Offers one sample, idling first at the rate of the current mode, and waits
  // for the transaction. The payload stays put while the block stalls it.
  task automatic offer_sample(input height_t s, input logic row_end, input logic flat);
    int          idle_pct;
    height_out_t h;
    idle_pct = (idle_mode == ModeSenderLight) ? 25 :
               (idle_mode == ModeSenderHeavy) ? 49 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    row_end_i  <= row_end;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // The transaction happened at this edge.
    predict_row_step(s, row_end);
    foreach (step_heights[i]) begin
      h = step_heights[i];
      if (flat) h.value = s;
      pending_heights.push_back(h);
    end
    samples_sent++;
    if (row_end) rows_sent++;
  endtask

  // Output side: checks each output transaction against the oldest expectation
  // and drives the stall for the next cycle. Once, when the no-idle stretch
  // begins, it holds the output off for a long run of cycles so that the queue
  // and the front end fill up and the block has to stall its input.
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk_i) begin
    height_out_t want;
    int          recv_pct;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_heights.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportLimit) begin
            $display("tb_top: unexpected output height %0d last %0b", value_o, last_o);
          end
        end else begin
          want = pending_heights.pop_front();
          heights_checked++;
          if (value_o !== want.value || last_o !== want.last) begin
            fail_count++;
            if (fail_count <= ReportLimit) begin
              $display("tb_top: height %0d: expected %0d last %0b, got %0d last %0b",
                       heights_checked, want.value, want.last, value_o, last_o);
            end
          end
        end
      end
      recv_pct = (idle_mode == ModeSenderLight) ? 49 :
                 (idle_mode == ModeSenderHeavy) ? 25 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (idle_mode == ModeNoIdle && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  // Stimulus: reset, the directed table, then random rows in three idle modes.
  initial begin
    int      row_len;
    height_t s;
    in_valid_i      = 1'b0;
    sample_i        = '0;
    row_end_i       = 1'b0;
    rst_ni          = 1'b0;
    idle_mode       = ModeSenderLight;
    fail_count      = 0;
    heights_checked = 0;
    samples_sent    = 0;
    rows_sent       = 0;
    random_sent     = 0;
    row_buf         = '{default: '0};
    row_fill        = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_sample(directed_rows[i].sample, directed_rows[i].row_end, directed_rows[i].flat);
    end

    // Random rows: mostly short, now and then a long one. The last row is cut
    // short so that the random part ends at its item count.
    while (random_sent < RandomItems) begin
      row_len = ($urandom_range(7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      if (row_len > RandomItems - random_sent) row_len = RandomItems - random_sent;
      for (int k = 0; k < row_len; k++) begin
        idle_mode = (random_sent < RandomItems / 3)     ? ModeSenderLight :
                    (random_sent < 2 * RandomItems / 3) ? ModeSenderHeavy : ModeNoIdle;
        s = random_height();
        offer_sample(s, (k == row_len - 1), 1'b0);
        random_sent++;
      end
    end
    in_valid_i <= 1'b0;
    idle_mode = ModeNoIdle;

    while (pending_heights.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb_top: %0d samples in %0d rows sent, %0d output heights checked",
             samples_sent, rows_sent, heights_checked);
    $display("tb_top: %0d failures, including overshoot and the long output hold",
             fail_count);
    if (fail_count == 0 && pending_heights.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/cru_pkg.sv
src/cru_front.sv
src/cru_queue.sv
src/cru_back.sv
src/cubic_row_upsampler.sv
dv/tb_top.sv
